FILE: hdl/slx_pkg.sv
// ---------------------------------------------------------------------------
// slx_pkg: shared types and constants for the small language lexer
// Token kind codes, character codes, keyword table and the result record
// passed from the scanner to the output queue.
// ---------------------------------------------------------------------------
package slx_pkg;

  // token kind codes
  localparam logic [5:0] KIND_UINT   = 6'd0;
  localparam logic [5:0] KIND_IDEN   = 6'd1;
  localparam logic [5:0] KIND_PLUS   = 6'd2;
  localparam logic [5:0] KIND_MINUS  = 6'd3;
  localparam logic [5:0] KIND_MULT   = 6'd4;
  localparam logic [5:0] KIND_DIV    = 6'd5;
  localparam logic [5:0] KIND_LESS   = 6'd6;
  localparam logic [5:0] KIND_LEQ    = 6'd7;
  localparam logic [5:0] KIND_GREAT  = 6'd8;
  localparam logic [5:0] KIND_GEQ    = 6'd9;
  localparam logic [5:0] KIND_EQUAL  = 6'd10;
  localparam logic [5:0] KIND_NEQ    = 6'd11;
  localparam logic [5:0] KIND_ASSIGN = 6'd12;
  localparam logic [5:0] KIND_CHAR   = 6'd13;
  localparam logic [5:0] KIND_STRING = 6'd14;
  localparam logic [5:0] KIND_COMMA  = 6'd15;
  localparam logic [5:0] KIND_SEMI   = 6'd16;
  localparam logic [5:0] KIND_COLON  = 6'd17;
  localparam logic [5:0] KIND_LPAR   = 6'd18;
  localparam logic [5:0] KIND_RPAR   = 6'd19;
  localparam logic [5:0] KIND_LBRACK = 6'd20;
  localparam logic [5:0] KIND_RBRACK = 6'd21;
  localparam logic [5:0] KIND_LBRACE = 6'd22;
  localparam logic [5:0] KIND_RBRACE = 6'd23;
  localparam logic [5:0] KIND_KW0    = 6'd24;
  localparam logic [5:0] KIND_END    = 6'd36;
  localparam logic [5:0] KIND_ERROR  = 6'd37;

  // character codes
  localparam logic [7:0] CH_NUL      = 8'd0;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DQUOTE   = 8'd34;
  localparam logic [7:0] CH_SQUOTE   = 8'd39;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  // class of the token being built
  typedef enum logic [3:0] {
    P_IDLE, P_IDENT, P_NUM, P_LT, P_GT, P_EQ, P_BANG, P_CQ, P_CB, P_STR
  } pclass_t;

  // keyword table, first keyword maps to KIND_KW0
  localparam int KW_COUNT = 12;
  localparam int KW_CHARS = 7;
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00},
    '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h", 8'h00},
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "e", "f", "a", "u", "l", "t"},
    '{"s", "c", "a", "n", "f", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", "f", 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd4, 4'd4, 4'd4, 4'd2, 4'd6, 4'd4, 4'd7, 4'd5, 4'd6, 4'd6
  };

  // output queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // one finished token
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [7:0]  token_length;
    logic        last;
  } slx_result_t;

  // results produced by one accepted character
  typedef struct packed {
    logic [1:0]  count;
    slx_result_t res0;
    slx_result_t res1;
  } slx_push_t;

  // single character operator lookup
  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } single_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == "_") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit = 1'b1;
    unique case (c)
      "+":     s.kind = KIND_PLUS;
      "-":     s.kind = KIND_MINUS;
      "*":     s.kind = KIND_MULT;
      "/":     s.kind = KIND_DIV;
      ",":     s.kind = KIND_COMMA;
      ";":     s.kind = KIND_SEMI;
      ":":     s.kind = KIND_COLON;
      "(":     s.kind = KIND_LPAR;
      ")":     s.kind = KIND_RPAR;
      "[":     s.kind = KIND_LBRACK;
      "]":     s.kind = KIND_RBRACK;
      "{":     s.kind = KIND_LBRACE;
      "}":     s.kind = KIND_RBRACE;
      default: begin
        s.hit  = 1'b0;
        s.kind = KIND_UINT;
      end
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/slx_scan.sv
// ---------------------------------------------------------------------------
// slx_scan: character scanner with lexer state
// Holds the pending token class, line and length counters and the keyword
// characters, and turns one accepted character into up to two results.
// ---------------------------------------------------------------------------
module slx_scan #(
  parameter int LINE_BITS   = 16,
  parameter int KEYWORD_MAX = 7,
  parameter int LENGTH_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        ch,
  output slx_pkg::slx_push_t push
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  // state registers
  slx_pkg::pclass_t        pend;
  logic [LINE_BITS-1:0]    line_count;
  logic [LENGTH_BITS-1:0]  length_count;
  logic                    lz;
  logic                    halted;
  logic [7:0]              kw_chars [KEYWORD_MAX];

  slx_pkg::pclass_t        pend_next;
  logic [LINE_BITS-1:0]    line_count_next;
  logic [LENGTH_BITS-1:0]  length_count_next;
  logic                    lz_next;
  logic                    halted_next;

  // decode scratch
  logic                    used;
  logic                    clr;
  logic                    add_en;
  logic [LENGTH_BITS-1:0]  add_pos;
  logic                    f_en;
  logic [LENGTH_BITS-1:0]  f_len;
  logic                    a_en;
  logic [5:0]              a_kind;
  logic [LENGTH_BITS-1:0]  a_len;
  logic                    b_en;
  logic [5:0]              b_kind;
  logic [LENGTH_BITS-1:0]  b_len;
  logic [LENGTH_BITS-1:0]  len_inc;
  logic [LENGTH_BITS-1:0]  err_len;
  logic [5:0]              kw_kind;
  logic                    kw_hit;
  logic                    alnum;
  slx_pkg::single_t        single;
  logic [15:0]             line_out;
  slx_pkg::slx_result_t    res_a;
  slx_pkg::slx_result_t    res_b;

  function automatic logic [LENGTH_BITS-1:0] len_sat_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
  endfunction

  function automatic logic [7:0] len_out(input logic [LENGTH_BITS-1:0] v);
    return (16'(v) > 16'd255) ? 8'hFF : 8'(v);
  endfunction

  assign alnum   = slx_pkg::is_alpha(ch) || slx_pkg::is_digit(ch);
  assign single  = slx_pkg::single_kind(ch);
  assign len_inc = len_sat_inc(length_count);
  assign err_len = (ch != slx_pkg::CH_NUL) ? len_inc : length_count;

  // keyword match over the stored characters
  always_comb begin
    kw_kind = slx_pkg::KIND_IDEN;
    for (int k = slx_pkg::KW_COUNT - 1; k >= 0; k--) begin
      kw_hit = (32'(length_count) == 32'(slx_pkg::KW_LEN[k]));
      for (int j = 0; j < slx_pkg::KW_CHARS; j++) begin
        if ((32'(j) < 32'(slx_pkg::KW_LEN[k])) && (kw_chars[j] != slx_pkg::KW_TEXT[k][j])) begin
          kw_hit = 1'b0;
        end
      end
      if (kw_hit) begin
        kw_kind = slx_pkg::KIND_KW0 + 6'(k);
      end
    end
  end

  // next state and results for the current character
  always_comb begin
    pend_next         = pend;
    line_count_next   = line_count;
    length_count_next = length_count;
    lz_next           = lz;
    halted_next       = halted;
    used    = 1'b0;
    clr     = 1'b0;
    add_en  = 1'b0;
    add_pos = length_count;
    f_en    = 1'b0;
    f_len   = length_count;
    a_en    = 1'b0;
    a_kind  = slx_pkg::KIND_UINT;
    a_len   = '0;
    b_en    = 1'b0;
    b_kind  = slx_pkg::KIND_UINT;
    b_len   = '0;

    if (halted) begin
      // skip input until end of text
      if (ch == slx_pkg::CH_NUL) begin
        b_en   = 1'b1;
        b_kind = slx_pkg::KIND_END;
        clr    = 1'b1;
      end
    end else begin
      // continue or close the pending token
      unique case (pend)
        slx_pkg::P_IDENT: begin
          if (alnum) begin
            add_en = 1'b1;
            used   = 1'b1;
          end else begin
            a_en      = 1'b1;
            a_kind    = kw_kind;
            a_len     = length_count;
            pend_next = slx_pkg::P_IDLE;
          end
        end
        slx_pkg::P_NUM: begin
          if (slx_pkg::is_digit(ch)) begin
            add_en = 1'b1;
            used   = 1'b1;
          end else if (lz && (length_count > LENGTH_BITS'(1))) begin
            f_en  = 1'b1;
            f_len = length_count;
            used  = 1'b1;
          end else begin
            a_en      = 1'b1;
            a_kind    = slx_pkg::KIND_UINT;
            a_len     = length_count;
            pend_next = slx_pkg::P_IDLE;
          end
        end
        slx_pkg::P_LT, slx_pkg::P_GT, slx_pkg::P_EQ: begin
          a_en = 1'b1;
          if (ch == "=") begin
            a_kind = (pend == slx_pkg::P_LT) ? slx_pkg::KIND_LEQ :
                     (pend == slx_pkg::P_GT) ? slx_pkg::KIND_GEQ : slx_pkg::KIND_EQUAL;
            a_len  = LENGTH_BITS'(2);
            used   = 1'b1;
          end else begin
            a_kind = (pend == slx_pkg::P_LT) ? slx_pkg::KIND_LESS :
                     (pend == slx_pkg::P_GT) ? slx_pkg::KIND_GREAT : slx_pkg::KIND_ASSIGN;
            a_len  = LENGTH_BITS'(1);
          end
          pend_next = slx_pkg::P_IDLE;
        end
        slx_pkg::P_BANG: begin
          used = 1'b1;
          if (ch == "=") begin
            a_en      = 1'b1;
            a_kind    = slx_pkg::KIND_NEQ;
            a_len     = LENGTH_BITS'(2);
            pend_next = slx_pkg::P_IDLE;
          end else begin
            f_en  = 1'b1;
            f_len = err_len;
          end
        end
        slx_pkg::P_CQ: begin
          used = 1'b1;
          if (alnum || ch == "+" || ch == "-" || ch == "*" || ch == "/") begin
            add_en    = 1'b1;
            pend_next = slx_pkg::P_CB;
          end else begin
            f_en  = 1'b1;
            f_len = err_len;
          end
        end
        slx_pkg::P_CB: begin
          used = 1'b1;
          if (ch == slx_pkg::CH_SQUOTE) begin
            a_en      = 1'b1;
            a_kind    = slx_pkg::KIND_CHAR;
            a_len     = len_inc;
            pend_next = slx_pkg::P_IDLE;
          end else begin
            f_en  = 1'b1;
            f_len = err_len;
          end
        end
        slx_pkg::P_STR: begin
          used = 1'b1;
          if (ch >= slx_pkg::CH_PRINT_LO && ch <= slx_pkg::CH_PRINT_HI &&
              ch != slx_pkg::CH_DQUOTE) begin
            add_en = 1'b1;
          end else if (ch == slx_pkg::CH_DQUOTE) begin
            a_en      = 1'b1;
            a_kind    = slx_pkg::KIND_STRING;
            a_len     = len_inc;
            pend_next = slx_pkg::P_IDLE;
          end else begin
            f_en  = 1'b1;
            f_len = err_len;
          end
        end
        default: pend_next = slx_pkg::P_IDLE;
      endcase

      // failure inside a pending token
      if (f_en) begin
        a_en   = 1'b1;
        a_kind = slx_pkg::KIND_ERROR;
        a_len  = f_len;
        if (ch == slx_pkg::CH_NUL) begin
          b_en   = 1'b1;
          b_kind = slx_pkg::KIND_END;
          clr    = 1'b1;
        end else begin
          halted_next = 1'b1;
          pend_next   = slx_pkg::P_IDLE;
        end
      end

      // character starts something new
      if (!used) begin
        length_count_next = '0;
        lz_next           = 1'b0;
        add_pos           = '0;
        priority if (ch == slx_pkg::CH_NUL) begin
          b_en   = 1'b1;
          b_kind = slx_pkg::KIND_END;
          clr    = 1'b1;
        end else if (ch == slx_pkg::CH_SPACE || ch == slx_pkg::CH_TAB) begin
          pend_next = pend_next;
        end else if (ch == slx_pkg::CH_NL) begin
          if (line_count != LINE_MAX) begin
            line_count_next = line_count + LINE_BITS'(1);
          end
        end else if (slx_pkg::is_alpha(ch)) begin
          add_en    = 1'b1;
          pend_next = slx_pkg::P_IDENT;
        end else if (slx_pkg::is_digit(ch)) begin
          add_en    = 1'b1;
          lz_next   = (ch == "0");
          pend_next = slx_pkg::P_NUM;
        end else if (single.hit) begin
          b_en   = 1'b1;
          b_kind = single.kind;
          b_len  = LENGTH_BITS'(1);
        end else if (ch == "<" || ch == ">" || ch == "=" || ch == "!" ||
                     ch == slx_pkg::CH_SQUOTE || ch == slx_pkg::CH_DQUOTE) begin
          add_en    = 1'b1;
          pend_next = (ch == "<") ? slx_pkg::P_LT :
                      (ch == ">") ? slx_pkg::P_GT :
                      (ch == "=") ? slx_pkg::P_EQ :
                      (ch == "!") ? slx_pkg::P_BANG :
                      (ch == slx_pkg::CH_SQUOTE) ? slx_pkg::P_CQ : slx_pkg::P_STR;
        end else begin
          b_en        = 1'b1;
          b_kind      = slx_pkg::KIND_ERROR;
          b_len       = LENGTH_BITS'(1);
          halted_next = 1'b1;
          pend_next   = slx_pkg::P_IDLE;
        end
      end
    end

    if (add_en) begin
      length_count_next = len_sat_inc(add_pos);
    end

    // end of text returns everything to reset
    if (clr) begin
      pend_next         = slx_pkg::P_IDLE;
      line_count_next   = LINE_BITS'(1);
      length_count_next = '0;
      lz_next           = 1'b0;
      halted_next       = 1'b0;
    end
  end

  // pack results, all share the current line
  assign line_out = (32'(line_count) > 32'd65535) ? 16'hFFFF : 16'(line_count);

  always_comb begin
    res_a.kind         = a_kind;
    res_a.line         = line_out;
    res_a.token_length = len_out(a_len);
    res_a.last         = !b_en;
    res_b.kind         = b_kind;
    res_b.line         = line_out;
    res_b.token_length = len_out(b_len);
    res_b.last         = 1'b1;
    if (a_en) begin
      push.res0 = res_a;
      push.res1 = res_b;
    end else begin
      push.res0 = res_b;
      push.res1 = res_b;
    end
    push.count = fire ? (2'(a_en) + 2'(b_en)) : 2'd0;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= slx_pkg::P_IDLE;
      line_count   <= LINE_BITS'(1);
      length_count <= '0;
      lz           <= 1'b0;
      halted       <= 1'b0;
    end else if (fire) begin
      pend         <= pend_next;
      line_count   <= line_count_next;
      length_count <= length_count_next;
      lz           <= lz_next;
      halted       <= halted_next;
    end
  end

  // keyword character store, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_MAX; i++) begin
      if (fire && add_en && (32'(add_pos) == 32'(i))) begin
        kw_chars[i] <= ch;
      end
    end
  end

endmodule

FILE: hdl/slx_outq.sv
// ---------------------------------------------------------------------------
// slx_outq: result queue
// Four-entry queue that takes up to two results per cycle and hands out
// one per transfer; signals full while fewer than two entries are free.
// ---------------------------------------------------------------------------
module slx_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  slx_pkg::slx_push_t   push,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slx_pkg::slx_result_t head
);

  slx_pkg::slx_result_t             q [slx_pkg::QUEUE_DEPTH];
  logic [slx_pkg::QPTR_BITS-1:0]    rptr;
  logic [slx_pkg::QPTR_BITS-1:0]    wptr;
  logic [slx_pkg::QCNT_BITS-1:0]    count;
  logic                             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign head      = q[rptr];
  assign full      = count > slx_pkg::QCNT_BITS'(slx_pkg::QUEUE_DEPTH - 2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      rptr  <= rptr + slx_pkg::QPTR_BITS'(pop);
      wptr  <= wptr + slx_pkg::QPTR_BITS'(push.count);
      count <= count + slx_pkg::QCNT_BITS'(push.count) - slx_pkg::QCNT_BITS'(pop);
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      q[wptr + slx_pkg::QPTR_BITS'(1)] <= push.res1;
    end
  end

endmodule

FILE: hdl/small_language_lexer.sv
// ---------------------------------------------------------------------------
// small_language_lexer: streaming lexer, one source byte per transfer
// Results pass through the registered result queue before they are offered.
// Throughput: one character per cycle; a character that closes two tokens
// gives two results, handed out one per transfer, and input stalls while the
// result queue holds more than two entries.
// Reset: synchronous, clears lexer state and the queue; keyword store is not cleared.
// ---------------------------------------------------------------------------
module small_language_lexer #(
  parameter int LINE_BITS   = 16,
  parameter int KEYWORD_MAX = 7,
  parameter int LENGTH_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  kind,
  output logic [15:0] line,
  output logic [7:0]  token_length,
  output logic        last
);

  slx_pkg::slx_push_t   push;
  slx_pkg::slx_result_t head;
  logic                 full;
  logic                 fire;

  // input transfer
  assign in_stall = full;
  assign fire     = in_valid && !full;

  slx_scan #(
    .LINE_BITS   (LINE_BITS),
    .KEYWORD_MAX (KEYWORD_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (ch),
    .push (push)
  );

  slx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields
  assign kind         = head.kind;
  assign line         = head.line;
  assign token_length = head.token_length;
  assign last         = head.last;

endmodule

FILE: hdl/slx_checker.sv
// ---------------------------------------------------------------------------
// slx_checker: port checks for the small language lexer
// Watches the top level ports for reset, output hold and token rules.
// ---------------------------------------------------------------------------
module slx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  kind,
  input logic [15:0] line,
  input logic [7:0]  token_length,
  input logic        last
);

  // reset leaves nothing pending and input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("results or stall present after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_hold_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(kind) && $stable(line) && $stable(token_length) && $stable(last)))
    else $error("result changed while stalled");

  // end of text has no length and closes the character's results
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == slx_pkg::KIND_END) |-> (token_length == 8'd0 && last))
    else $error("bad end token");

  // line numbers start at one
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line != 16'd0))
    else $error("line number zero");

endmodule

bind small_language_lexer slx_checker u_slx_checker (.*);
